// ===== rtl/skm_pkg.sv =====
// ---------------------------------------------------------------------------
// skm_pkg
// Shared types and constants of the sorted key to id map.
// ---------------------------------------------------------------------------
package skm_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_BYTES_DEF = 8;

  localparam int MODE_W   = 2;
  localparam int KEY_IN_W = 64;
  localparam int NUM_W    = 6;
  localparam int STATUS_W = 3;
  localparam int ID_OUT_W = 6;
  localparam int TOTAL_W  = 7;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIND_INSERT = 2'd0,
    MODE_LOOKUP      = 2'd1,
    MODE_BY_ID       = 2'd2,
    MODE_BY_POS      = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef struct packed {
    logic [NUM_W-1:0]    num;
    logic [KEY_IN_W-1:0] key;
    mode_t               mode;
  } item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]  total;
    logic [KEY_IN_W-1:0] key;
    logic [ID_OUT_W-1:0] id;
    status_t             status;
  } result_t;

endpackage

// ===== rtl/skm_ram.sv =====
// ---------------------------------------------------------------------------
// skm_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ---------------------------------------------------------------------------
module skm_ram #(
  parameter int DEPTH = skm_pkg::CAPACITY_DEF,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/skm_ctrl.sv =====
// ---------------------------------------------------------------------------
// skm_ctrl
// Request sequencer: binary search, insert shift and indexed reads over the
// entry memory (key and id by sorted position) and the position memory.
// ---------------------------------------------------------------------------
module skm_ctrl #(
  parameter int CAPACITY  = skm_pkg::CAPACITY_DEF,
  parameter int KEY_BYTES = skm_pkg::KEY_BYTES_DEF,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1),
  localparam int KW    = 8 * KEY_BYTES,
  localparam int ENT_W = KW + IDX_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  skm_pkg::item_t    in_item,
  output logic              res_valid,
  input  logic              res_ready,
  output skm_pkg::result_t  res,
  output logic [IDX_W-1:0]  ent_raddr,
  input  logic [ENT_W-1:0]  ent_rdata,
  output logic              ent_we,
  output logic [IDX_W-1:0]  ent_waddr,
  output logic [ENT_W-1:0]  ent_wdata,
  output logic [IDX_W-1:0]  pos_raddr,
  input  logic [IDX_W-1:0]  pos_rdata,
  output logic              pos_we,
  output logic [IDX_W-1:0]  pos_waddr,
  output logic [IDX_W-1:0]  pos_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_PROBE,
    S_CMP,
    S_POS,
    S_KEY,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t                            state;
  skm_pkg::mode_t                    mode_r;
  logic [KW-1:0]                     key_r;
  logic [skm_pkg::NUM_W-1:0]         num_r;
  logic [CNT_W-1:0]                  count;
  logic [CNT_W-1:0]                  lo;
  logic [CNT_W-1:0]                  hi;
  logic [IDX_W-1:0]                  mid;
  logic [IDX_W-1:0]                  pos;
  logic [IDX_W-1:0]                  i;
  logic [IDX_W-1:0]                  wa;
  logic                              pend;
  skm_pkg::status_t                  status_r;
  logic [IDX_W-1:0]                  id_r;
  logic [KW-1:0]                     kout_r;

  logic [CNT_W-1:0] mid_c;
  logic [KW-1:0]    rd_key;
  logic [IDX_W-1:0] rd_id;

  assign mid_c  = lo + ((hi - lo) >> 1);
  assign rd_key = ent_rdata[KW-1:0];
  assign rd_id  = ent_rdata[KW +: IDX_W];

  assign in_ready   = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign res.status = status_r;
  assign res.id     = skm_pkg::ID_OUT_W'(id_r);
  assign res.key    = skm_pkg::KEY_IN_W'(kout_r);
  assign res.total  = skm_pkg::TOTAL_W'(count);

  // memory addressing per state
  always_comb begin
    ent_raddr = '0;
    pos_raddr = '0;
    ent_we    = 1'b0;
    ent_waddr = wa;
    ent_wdata = ent_rdata;
    pos_we    = 1'b0;
    pos_waddr = rd_id;
    pos_wdata = wa;
    unique case (state)
      S_START: begin
        pos_raddr = IDX_W'(num_r);
        ent_raddr = IDX_W'(num_r);
      end
      S_PROBE: begin
        ent_raddr = IDX_W'(mid_c);
      end
      S_POS: begin
        ent_raddr = pos_rdata;
      end
      S_SHIFT: begin
        ent_raddr = i - IDX_W'(1);
        if (pend) begin
          // move entry up one slot and repoint its id
          ent_we = 1'b1;
          pos_we = 1'b1;
        end else if (i == pos) begin
          ent_we    = 1'b1;
          ent_waddr = pos;
          ent_wdata = {IDX_W'(count), key_r};
          pos_we    = 1'b1;
          pos_waddr = IDX_W'(count);
          pos_wdata = pos;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= in_item.mode;
            key_r  <= in_item.key[KW-1:0];
            num_r  <= in_item.num;
            state  <= S_START;
          end
        end
        S_START: begin
          if (mode_r == skm_pkg::MODE_FIND_INSERT || mode_r == skm_pkg::MODE_LOOKUP) begin
            lo    <= '0;
            hi    <= count;
            state <= S_PROBE;
          end else if (num_r >= count) begin
            status_r <= skm_pkg::ST_RANGE;
            id_r     <= '0;
            kout_r   <= '0;
            state    <= S_DONE;
          end else if (mode_r == skm_pkg::MODE_BY_ID) begin
            state <= S_POS;
          end else begin
            state <= S_KEY;
          end
        end
        S_PROBE: begin
          id_r   <= '0;
          kout_r <= '0;
          priority if (lo < hi) begin
            mid   <= IDX_W'(mid_c);
            state <= S_CMP;
          end else if (mode_r == skm_pkg::MODE_LOOKUP) begin
            status_r <= skm_pkg::ST_NOT_FOUND;
            state    <= S_DONE;
          end else if (count >= CNT_W'(CAPACITY)) begin
            status_r <= skm_pkg::ST_FULL;
            state    <= S_DONE;
          end else begin
            pos   <= IDX_W'(lo);
            i     <= IDX_W'(count);
            pend  <= 1'b0;
            state <= S_SHIFT;
          end
        end
        S_CMP: begin
          priority if (rd_key < key_r) begin
            lo    <= CNT_W'(mid) + CNT_W'(1);
            state <= S_PROBE;
          end else if (rd_key > key_r) begin
            hi    <= CNT_W'(mid);
            state <= S_PROBE;
          end else begin
            status_r <= skm_pkg::ST_FOUND;
            id_r     <= rd_id;
            kout_r   <= '0;
            state    <= S_DONE;
          end
        end
        S_POS: begin
          state <= S_KEY;
        end
        S_KEY: begin
          status_r <= skm_pkg::ST_FOUND;
          kout_r   <= rd_key;
          id_r     <= (mode_r == skm_pkg::MODE_BY_ID) ? IDX_W'(num_r) : rd_id;
          state    <= S_DONE;
        end
        S_SHIFT: begin
          pend <= 1'b0;
          if (i > pos) begin
            pend <= 1'b1;
            wa   <= i;
            i    <= i - IDX_W'(1);
          end else if (!pend) begin
            count    <= count + CNT_W'(1);
            status_r <= skm_pkg::ST_INSERTED;
            id_r     <= IDX_W'(count);
            kout_r   <= '0;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_entry_write_in_shift: assert property (@(posedge clk) disable iff (rst)
    ent_we |-> state == S_SHIFT)
    else $error("entry memory written outside insert");

  a_count_steps_by_one: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |-> count == $past(count) + CNT_W'(1))
    else $error("entry count moved by other than one");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE || state == S_CMP) |-> (lo <= hi && hi <= count))
    else $error("search window out of order");

  a_shift_no_collision: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && pend && i > pos) |-> ent_waddr != ent_raddr)
    else $error("shift write hits the address being read");

  a_insert_nonempty: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status_r == skm_pkg::ST_INSERTED) |-> count != '0)
    else $error("insert reported with empty table");

endmodule

// ===== rtl/sorted_key_to_id_map.sv =====
// ---------------------------------------------------------------------------
// sorted_key_to_id_map
// Sorted key table with insertion-order ids, served one request at a time.
// ---------------------------------------------------------------------------
// One request is worked at a time. Keys and ids live in one memory ordered by
// key, and a second memory maps each id to its sorted position; both have a
// registered read. Every request passes the idle state that takes the word, a
// start state and a done state, plus its own work. Each search probe is a probe
// state and a compare state, at most clog2(CAPACITY)+1 probes (7 at 64
// entries), and one more probe state when the key is missing. An insert then
// moves one entry per cycle through the entries above the insert point. Key by
// id adds a position state and a key state, key by position the key state, and
// an out-of-range number goes straight to done. The slowest request is an
// insert at the front of a table holding CAPACITY - 1 entries. The result then
// sits in an output register, so the next word can be taken while a result
// waits on the master side; while a second result waits, the done cycle
// stretches and the slave side stays closed.
module sorted_key_to_id_map #(
  parameter int CAPACITY  = skm_pkg::CAPACITY_DEF,
  parameter int KEY_BYTES = skm_pkg::KEY_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // mode[1:0], key_in[65:2], number_in[71:66]
  input  logic [skm_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status[2:0], id_out[8:3], key_out[72:9], entry_total[79:73]
  output logic [skm_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int KW    = 8 * KEY_BYTES;
  localparam int ENT_W = KW + IDX_W;

  skm_pkg::item_t   item;
  skm_pkg::result_t res;
  logic             res_valid;
  logic             res_ready;

  logic [IDX_W-1:0] ent_raddr;
  logic [ENT_W-1:0] ent_rdata;
  logic             ent_we;
  logic [IDX_W-1:0] ent_waddr;
  logic [ENT_W-1:0] ent_wdata;
  logic [IDX_W-1:0] pos_raddr;
  logic [IDX_W-1:0] pos_rdata;
  logic             pos_we;
  logic [IDX_W-1:0] pos_waddr;
  logic [IDX_W-1:0] pos_wdata;

  skm_pkg::result_t out_word;

  assign item.mode = skm_pkg::mode_t'(s_tdata[1:0]);
  assign item.key  = s_tdata[65:2];
  assign item.num  = s_tdata[71:66];

  skm_ctrl #(
    .CAPACITY  (CAPACITY),
    .KEY_BYTES (KEY_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ent_raddr (ent_raddr),
    .ent_rdata (ent_rdata),
    .ent_we    (ent_we),
    .ent_waddr (ent_waddr),
    .ent_wdata (ent_wdata),
    .pos_raddr (pos_raddr),
    .pos_rdata (pos_rdata),
    .pos_we    (pos_we),
    .pos_waddr (pos_waddr),
    .pos_wdata (pos_wdata)
  );

  // key and id by sorted position
  skm_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENT_W)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // sorted position by id
  skm_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (IDX_W)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign m_tdata = out_word;

endmodule

// ===== tb/sv/sorted_key_to_id_map_test.sv =====
// ---------------------------------------------------------------------------
// sorted_key_to_id_map_test
// Self-checking bench for the sorted key to id map. Requests go in on the
// slave stream and are scored against an in-bench copy of the key table
// (sorted keys, their ids and the id to position map) as each word is taken.
// Directed requests hit the empty table, extreme keys, short strings and
// range errors; random requests then grow the table until it is full and
// keep working it, with random gaps on both sides, one back-to-back
// stretch and one long master-side hold-off.
// ---------------------------------------------------------------------------
module sorted_key_to_id_map_test;

  localparam int          CAPACITY      = skm_pkg::CAPACITY_DEF;
  localparam int          ITEM_GOAL     = 1900;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          SETTLE_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [skm_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [skm_pkg::OUT_DATA_W-1:0] m_tdata;

  sorted_key_to_id_map u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the table
  logic [skm_pkg::KEY_IN_W-1:0] map_keys   [CAPACITY];
  logic [skm_pkg::ID_OUT_W-1:0] map_ids    [CAPACITY];
  logic [skm_pkg::NUM_W-1:0]    slot_of_id [CAPACITY];
  int                           map_count = 0;

  skm_pkg::result_t pending_results[$];
  int               errors     = 0;
  int               sent_total = 0;
  int               n_inserted = 0;
  int               n_hits     = 0;
  int               n_misses   = 0;
  int               n_full     = 0;
  int               n_range    = 0;
  bit               no_idle    = 1'b0;
  int               stall_ask  = 0;
  int               stall_seen = 0;
  int               hold_left  = 0;
  int unsigned      cycle_count = 0;

  function automatic skm_pkg::result_t predict_map(skm_pkg::item_t it);
    skm_pkg::result_t r;
    int               lo;
    int               hi;
    int               mid;
    bit               hit;
    r = '0;
    r.status = skm_pkg::ST_FOUND;
    if (it.mode == skm_pkg::MODE_FIND_INSERT || it.mode == skm_pkg::MODE_LOOKUP) begin
      lo = 0;
      hi = map_count;
      hit = 1'b0;
      while (lo < hi && !hit) begin
        mid = (lo + hi) / 2;
        if (map_keys[mid] < it.key) begin
          lo = mid + 1;
        end else if (map_keys[mid] > it.key) begin
          hi = mid;
        end else begin
          hit = 1'b1;
          lo = mid;
        end
      end
      if (hit) begin
        r.id = map_ids[lo];
      end else if (it.mode == skm_pkg::MODE_LOOKUP) begin
        r.status = skm_pkg::ST_NOT_FOUND;
      end else if (map_count >= CAPACITY) begin
        r.status = skm_pkg::ST_FULL;
      end else begin
        // open a slot at the lower bound, moving larger keys up by one
        for (int i = map_count; i > lo; i--) begin
          map_keys[i] = map_keys[i-1];
          map_ids[i] = map_ids[i-1];
          slot_of_id[map_ids[i]] = skm_pkg::NUM_W'(i);
        end
        map_keys[lo] = it.key;
        map_ids[lo] = skm_pkg::ID_OUT_W'(map_count);
        slot_of_id[map_count] = skm_pkg::NUM_W'(lo);
        r.id = skm_pkg::ID_OUT_W'(map_count);
        r.status = skm_pkg::ST_INSERTED;
        map_count++;
      end
    end else if (int'(it.num) >= map_count) begin
      r.status = skm_pkg::ST_RANGE;
    end else if (it.mode == skm_pkg::MODE_BY_ID) begin
      r.id = it.num;
      r.key = map_keys[slot_of_id[it.num]];
    end else begin
      r.id = map_ids[it.num];
      r.key = map_keys[it.num];
    end
    r.total = skm_pkg::TOTAL_W'(map_count);
    return r;
  endfunction

  // one request word; returns at the falling edge after it was taken
  task automatic send_request(input skm_pkg::mode_t m,
                              input logic [skm_pkg::KEY_IN_W-1:0] k,
                              input logic [skm_pkg::NUM_W-1:0] n);
    skm_pkg::item_t   it;
    skm_pkg::result_t r;
    it.mode = m;
    it.key = k;
    it.num = n;
    while (!no_idle && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= it;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    r = predict_map(it);
    pending_results.push_back(r);
    sent_total++;
    case (r.status)
      skm_pkg::ST_INSERTED:  n_inserted++;
      skm_pkg::ST_FOUND:     n_hits++;
      skm_pkg::ST_NOT_FOUND: n_misses++;
      skm_pkg::ST_FULL:      n_full++;
      default:               n_range++;
    endcase
    @(negedge clk);
  endtask

  function automatic logic [skm_pkg::KEY_IN_W-1:0] known_key();
    if (map_count == 0) return {$urandom, $urandom};
    return map_keys[$urandom_range(map_count - 1)];
  endfunction

  // mostly fresh keys: wide random, neighbors of held keys, short strings
  function automatic logic [skm_pkg::KEY_IN_W-1:0] fresh_key();
    logic [skm_pkg::KEY_IN_W-1:0] k;
    int                           len;
    case ($urandom_range(3))
      0, 1: k = {$urandom, $urandom};
      2:    k = ($urandom_range(1)) ? known_key() + 1 : known_key() - 1;
      default: begin
        k = '0;
        len = $urandom_range(8, 1);
        for (int b = 0; b < len; b++) begin
          k[63 - 8*b -: 8] = 8'($urandom_range(8'h7a, 8'h61));
        end
      end
    endcase
    return k;
  endfunction

  task automatic random_request();
    int r;
    r = $urandom_range(99);
    if (r < 40) begin
      send_request(skm_pkg::MODE_FIND_INSERT,
                   ($urandom_range(9) < 7) ? known_key() : fresh_key(), 6'($urandom));
    end else if (r < 60) begin
      send_request(skm_pkg::MODE_LOOKUP,
                   ($urandom_range(1)) ? known_key() : fresh_key(), 6'($urandom));
    end else if (r < 80) begin
      send_request(skm_pkg::MODE_BY_ID, {$urandom, $urandom}, 6'($urandom));
    end else begin
      send_request(skm_pkg::MODE_BY_POS, {$urandom, $urandom}, 6'($urandom));
    end
  endtask

  task automatic test_empty_table();
    send_request(skm_pkg::MODE_LOOKUP, '0, '0);
    send_request(skm_pkg::MODE_BY_ID, '1, '0);
    send_request(skm_pkg::MODE_BY_POS, '0, '1);
  endtask

  task automatic test_edge_keys();
    send_request(skm_pkg::MODE_FIND_INSERT, 64'hffff_ffff_ffff_ffff, '0);
    send_request(skm_pkg::MODE_FIND_INSERT, 64'h0, '1);
    send_request(skm_pkg::MODE_FIND_INSERT, 64'h8000_0000_0000_0000, '0);
    send_request(skm_pkg::MODE_FIND_INSERT, 64'h7fff_ffff_ffff_ffff, '0);
    // "abc" sorts below "abcd" as the padding byte is zero
    send_request(skm_pkg::MODE_FIND_INSERT, 64'h6162_6364_0000_0000, '0);
    send_request(skm_pkg::MODE_FIND_INSERT, 64'h6162_6300_0000_0000, '0);
    send_request(skm_pkg::MODE_FIND_INSERT, 64'hffff_ffff_ffff_ffff, '0);
    send_request(skm_pkg::MODE_LOOKUP, 64'h0, '0);
    send_request(skm_pkg::MODE_LOOKUP, 64'h1, '0);
    send_request(skm_pkg::MODE_BY_ID, '0, 6'd0);
    send_request(skm_pkg::MODE_BY_ID, '0, 6'd5);
    send_request(skm_pkg::MODE_BY_ID, '0, 6'd6);
    send_request(skm_pkg::MODE_BY_POS, '0, 6'd0);
    send_request(skm_pkg::MODE_BY_POS, '0, 6'd5);
    send_request(skm_pkg::MODE_BY_POS, '0, 6'd6);
    send_request(skm_pkg::MODE_BY_POS, '1, 6'd63);
  endtask

  task automatic test_output_backpressure();
    stall_ask++;
    repeat (30) random_request();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (200) random_request();
    no_idle = 1'b0;
  endtask

  task automatic test_table_growth();
    while (map_count < CAPACITY) random_request();
  endtask

  task automatic test_full_table();
    send_request(skm_pkg::MODE_FIND_INSERT, fresh_key(), '0);
    send_request(skm_pkg::MODE_FIND_INSERT, known_key(), '0);
    send_request(skm_pkg::MODE_LOOKUP, fresh_key(), '0);
    send_request(skm_pkg::MODE_BY_ID, '0, 6'd63);
    send_request(skm_pkg::MODE_BY_POS, '0, 6'd63);
    send_request(skm_pkg::MODE_BY_POS, '0, 6'd0);
  endtask

  task automatic test_random_full();
    while (sent_total < ITEM_GOAL) random_request();
  endtask

  // master side: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (stall_ask != stall_seen) begin
      stall_seen <= stall_ask;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(99) < 29) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    skm_pkg::result_t got;
    skm_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        end
        if (got.id != want.id) begin
          errors++;
          $display("%0t: id_out expected %0d got %0d", $time, want.id, got.id);
        end
        if (got.key != want.key) begin
          errors++;
          $display("%0t: key_out expected %h got %h", $time, want.key, got.key);
        end
        if (got.total != want.total) begin
          errors++;
          $display("%0t: entry_total expected %0d got %0d", $time, want.total, got.total);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_table();
    test_edge_keys();
    test_output_backpressure();
    test_back_to_back();
    test_table_growth();
    test_full_table();
    test_random_full();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d requests: %0d inserts, %0d hits, %0d misses, %0d full, %0d range",
             sent_total, n_inserted, n_hits, n_misses, n_full, n_range);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
